// ===== hdl/pdm_pkg.sv =====
// Shared types and codes for the proximity detection merger.
// Holds sequencer states, command, action and register codes, and the table entry layout.
// No dependencies.
package pdm_pkg;

    localparam int TABLE_DEPTH_DEF  = 64;
    localparam int SOURCE_SPLIT_DEF = 99;
    localparam int THRESHOLD_RESET  = 200;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_ENABLE = 2'd1;

    localparam logic [1:0] KIND_DETECTION = 2'd0;
    localparam logic [1:0] KIND_START     = 2'd1;
    localparam logic [1:0] KIND_STOP      = 2'd2;

    localparam logic [2:0] ACT_APPENDED  = 3'd0;
    localparam logic [2:0] ACT_AVERAGED  = 3'd1;
    localparam logic [2:0] ACT_REPLACED  = 3'd2;
    localparam logic [2:0] ACT_UNCHANGED = 3'd3;
    localparam logic [2:0] ACT_DROPPED   = 3'd4;
    localparam logic [2:0] ACT_IGNORED   = 3'd5;
    localparam logic [2:0] ACT_STARTED   = 3'd6;
    localparam logic [2:0] ACT_STOPPED   = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_DX,
        S_DY,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [7:0]         cls;
        logic [15:0]        conf;
        logic signed [19:0] x;
        logic signed [19:0] y;
    } t_entry;

endpackage

// ===== hdl/proximity_detection_merger_unit.sv =====
// Proximity detection merger: radius-based deduplication of detections into two tables.
// One shared 21x21 multiplier under a small sequencer; tables in one on-chip memory.
// Depends on pdm_pkg.
//
// channel   direction  handshake                   payload
// command   in         i_start / o_busy            i_kind i_source_id i_class_id i_confidence
//                                                  i_pos_x i_pos_y
// result    out        o_done (one-cycle strobe)   o_action o_table_select o_entry_index
//                                                  o_table_count
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index i_cfg_data
//
// Commands, and detections while not accepting, give their result in the cycle after acceptance.
// A detection keeps o_busy high while it compares the stored entries; a miss also passes the
// append state. Each entry needs one table read and two passes through the shared multiplier
// (dx squared, dy squared), then a compare.
// Reset (synchronous, active low) empties both tables by clearing their counts; no sweep.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module proximity_detection_merger_unit #(
    parameter int TABLE_DEPTH  = pdm_pkg::TABLE_DEPTH_DEF,
    parameter int SOURCE_SPLIT = pdm_pkg::SOURCE_SPLIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_kind,
    input  logic [9:0]                      i_source_id,
    input  logic [7:0]                      i_class_id,
    input  logic [15:0]                     i_confidence,
    input  logic signed [19:0]              i_pos_x,
    input  logic signed [19:0]              i_pos_y,
    output logic                            o_done,
    output logic [2:0]                      o_action,
    output logic                            o_table_select,
    output logic [5:0]                      o_entry_index,
    output logic [6:0]                      o_table_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pdm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = IW + 1;
    localparam logic [9:0] SPLIT = 10'(SOURCE_SPLIT);

    pdm_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_cnt [2];
    logic [CW-1:0] n_cnt [2];
    logic          r_accepting, n_accepting;
    logic [IW-1:0] r_j, n_j;

    logic [15:0] r_thr;
    logic        r_avg;

    // latched transaction
    logic               r_tsel;
    logic [7:0]         r_cls;
    logic [15:0]        r_conf;
    logic signed [19:0] r_x;
    logic signed [19:0] r_y;

    logic [31:0] r_t2;
    logic [41:0] r_prod;
    logic [41:0] r_acc;

    // one half per table, addressed by {table, entry}
    pdm_pkg::t_entry r_mem [2**AW];
    pdm_pkg::t_entry r_rd;
    pdm_pkg::t_entry mem_wdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic            rd_en;
    logic [IW-1:0]   rd_idx;

    logic               r_done, n_done;
    logic [2:0]         r_action, n_action;
    logic               r_osel, n_osel;
    logic [5:0]         r_index, n_index;
    logic [6:0]         r_count, n_count;

    logic               latch;
    logic               in_tsel;
    logic [CW-1:0]      cnt_sel;
    logic signed [20:0] mul_a, mul_b;
    logic signed [41:0] mul_p;
    logic signed [20:0] dx, dy, sx, sy;
    logic [41:0]        d2;
    logic               hit;

    assign in_tsel = !(i_source_id > SPLIT);
    assign cnt_sel = r_cnt[r_tsel];
    assign mul_p   = mul_a * mul_b;
    assign dx      = {r_x[19], r_x} - {r_rd.x[19], r_rd.x};
    assign dy      = {r_y[19], r_y} - {r_rd.y[19], r_rd.y};
    assign sx      = {r_x[19], r_x} + {r_rd.x[19], r_rd.x};
    assign sy      = {r_y[19], r_y} + {r_rd.y[19], r_rd.y};
    assign d2      = r_acc + r_prod;
    assign hit     = d2 < {10'd0, r_t2};

    assign o_busy         = (r_state != pdm_pkg::S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_done         = r_done;
    assign o_action       = r_action;
    assign o_table_select = r_osel;
    assign o_entry_index  = r_index;
    assign o_table_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdm_pkg::S_IDLE;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_accepting <= 1'b0;
            r_j         <= '0;
            r_done      <= 1'b0;
            r_thr       <= 16'(pdm_pkg::THRESHOLD_RESET);
            r_avg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt[0]    <= n_cnt[0];
            r_cnt[1]    <= n_cnt[1];
            r_accepting <= n_accepting;
            r_j         <= n_j;
            r_done      <= n_done;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pdm_pkg::CFG_NEAR_THRESHOLD: r_thr <= i_cfg_data;
                    pdm_pkg::CFG_AVERAGE_ENABLE: r_avg <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_osel   <= n_osel;
        r_index  <= n_index;
        r_count  <= n_count;
        if (latch) begin
            r_tsel <= in_tsel;
            r_cls  <= i_class_id;
            r_conf <= i_confidence;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
        end
        if (r_state == pdm_pkg::S_THR) begin
            r_t2 <= mul_p[31:0];
        end
        if (r_state == pdm_pkg::S_DX) begin
            r_prod <= unsigned'(mul_p);
        end
        if (r_state == pdm_pkg::S_DY) begin
            r_acc  <= r_prod;
            r_prod <= unsigned'(mul_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= r_mem[{r_tsel, rd_idx}];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt[0]    = r_cnt[0];
        n_cnt[1]    = r_cnt[1];
        n_accepting = r_accepting;
        n_j         = r_j;
        n_done      = 1'b0;
        n_action    = r_action;
        n_osel      = r_osel;
        n_index     = r_index;
        n_count     = r_count;
        latch       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        rd_en       = 1'b0;
        rd_idx      = r_j;
        mul_a       = '0;
        mul_b       = '0;
        unique case (r_state)
            pdm_pkg::S_IDLE: begin
                if (i_start) begin
                    latch   = 1'b1;
                    n_osel  = in_tsel;
                    n_index = '0;
                    n_count = 7'(r_cnt[in_tsel]);
                    unique case (i_kind)
                        pdm_pkg::KIND_START: begin
                            n_cnt[0]    = '0;
                            n_cnt[1]    = '0;
                            n_accepting = 1'b1;
                            n_done      = 1'b1;
                            n_action    = pdm_pkg::ACT_STARTED;
                            n_count     = '0;
                        end
                        pdm_pkg::KIND_STOP: begin
                            n_accepting = 1'b0;
                            n_done      = 1'b1;
                            n_action    = pdm_pkg::ACT_STOPPED;
                        end
                        pdm_pkg::KIND_DETECTION: begin
                            if (r_accepting) begin
                                n_state = pdm_pkg::S_THR;
                            end else begin
                                n_done   = 1'b1;
                                n_action = pdm_pkg::ACT_IGNORED;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_action = pdm_pkg::ACT_IGNORED;
                        end
                    endcase
                end
            end
            pdm_pkg::S_THR: begin
                // square the radius, fetch the first entry
                mul_a  = signed'({5'd0, r_thr});
                mul_b  = signed'({5'd0, r_thr});
                n_j    = '0;
                rd_en  = 1'b1;
                rd_idx = '0;
                if (cnt_sel == '0) begin
                    n_state = pdm_pkg::S_FIN;
                end else begin
                    n_state = pdm_pkg::S_DX;
                end
            end
            pdm_pkg::S_DX: begin
                mul_a   = dx;
                mul_b   = dx;
                n_state = pdm_pkg::S_DY;
            end
            pdm_pkg::S_DY: begin
                mul_a   = dy;
                mul_b   = dy;
                n_state = pdm_pkg::S_CMP;
            end
            pdm_pkg::S_CMP: begin
                if (hit) begin
                    n_state   = pdm_pkg::S_IDLE;
                    n_done    = 1'b1;
                    n_osel    = r_tsel;
                    n_index   = 6'(r_j);
                    n_count   = 7'(cnt_sel);
                    mem_waddr = {r_tsel, r_j};
                    priority if (r_avg && (r_rd.cls == r_cls)) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{cls: r_rd.cls, conf: r_rd.conf, x: sx[20:1], y: sy[20:1]};
                        n_action  = pdm_pkg::ACT_AVERAGED;
                    end else if (r_conf > r_rd.conf) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{cls: r_cls, conf: r_rd.conf, x: r_rd.x, y: r_rd.y};
                        n_action  = pdm_pkg::ACT_REPLACED;
                    end else begin
                        n_action  = pdm_pkg::ACT_UNCHANGED;
                    end
                end else if ((CW'(r_j) + CW'(1)) == cnt_sel) begin
                    n_state = pdm_pkg::S_FIN;
                end else begin
                    // advance and prefetch the next entry
                    n_j     = r_j + IW'(1);
                    rd_en   = 1'b1;
                    rd_idx  = r_j + IW'(1);
                    n_state = pdm_pkg::S_DX;
                end
            end
            pdm_pkg::S_FIN: begin
                n_state = pdm_pkg::S_IDLE;
                n_done  = 1'b1;
                n_osel  = r_tsel;
                if (cnt_sel < CW'(TABLE_DEPTH)) begin
                    mem_we         = 1'b1;
                    mem_waddr      = {r_tsel, cnt_sel[IW-1:0]};
                    mem_wdata      = '{cls: r_cls, conf: r_conf, x: r_x, y: r_y};
                    n_cnt[r_tsel]  = cnt_sel + CW'(1);
                    n_action       = pdm_pkg::ACT_APPENDED;
                    n_index        = 6'(cnt_sel);
                    n_count        = 7'(cnt_sel + CW'(1));
                end else begin
                    n_action = pdm_pkg::ACT_DROPPED;
                    n_index  = '0;
                    n_count  = 7'(cnt_sel);
                end
            end
            default: n_state = pdm_pkg::S_IDLE;
        endcase
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while sequencer busy");

    a_cmd_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_kind != pdm_pkg::KIND_DETECTION)) |=> o_done)
        else $error("command transaction without result in next cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CW'(TABLE_DEPTH)) && (r_cnt[1] <= CW'(TABLE_DEPTH)))
        else $error("table count beyond depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdm_pkg::S_CMP) |-> (CW'(r_j) < cnt_sel))
        else $error("compare beyond filled entries");

    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_action == pdm_pkg::ACT_STARTED)) |-> (o_table_count == 7'd0))
        else $error("start result with nonzero count");

endmodule

// ===== dv/proximity_detection_merger_unit_tb.sv =====
// Self-checking testbench for proximity_detection_merger_unit: directed and random detections
// against a merge predictor, with register writes between phases.
// Depends on pdm_pkg and the unit RTL.
module proximity_detection_merger_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = pdm_pkg::TABLE_DEPTH_DEF;
    localparam int SOURCE_SPLIT = pdm_pkg::SOURCE_SPLIT_DEF;
    localparam int PHASE_ITEMS  = 200;
    localparam int SETTLE_CYCLES = 3 * TABLE_DEPTH + 10;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         source_id;
        logic [7:0]         class_id;
        logic [15:0]        confidence;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
    } t_detection;

    typedef struct packed {
        logic [2:0] action;
        logic       table_select;
        logic [5:0] entry_index;
        logic [6:0] table_count;
    } t_outcome;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_start = 1'b0;
    logic                            o_busy;
    logic [1:0]                      i_kind = pdm_pkg::KIND_DETECTION;
    logic [9:0]                      i_source_id = '0;
    logic [7:0]                      i_class_id = '0;
    logic [15:0]                     i_confidence = '0;
    logic signed [19:0]              i_pos_x = '0;
    logic signed [19:0]              i_pos_y = '0;
    logic                            o_done;
    logic [2:0]                      o_action;
    logic                            o_table_select;
    logic [5:0]                      o_entry_index;
    logic [6:0]                      o_table_count;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [pdm_pkg::CFG_INDEX_W-1:0] i_cfg_index = pdm_pkg::CFG_NEAR_THRESHOLD;
    logic [15:0]                     i_cfg_data = '0;

    proximity_detection_merger_unit u_top (.*);

    // Merge state mirrored by the predictor; index 0 is the first table, 1 the second.
    pdm_pkg::t_entry stored_entry [2][TABLE_DEPTH];
    int unsigned     stored_count [2] = '{0, 0};
    bit              accepting = 1'b0;
    int unsigned     near_thr = pdm_pkg::THRESHOLD_RESET;
    bit              avg_enable = 1'b0;

    t_detection  pending_items [$];
    t_outcome    expected_results [$];
    int          outstanding = 0;
    int          sent_count = 0;
    int          error_count = 0;
    bit          cmd_taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned calm_left = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR: %s", msg);
    endfunction

    function automatic t_outcome merge_detection(t_detection d);
        t_outcome        o;
        int unsigned     tsel;
        int unsigned     n;
        int unsigned     idx;
        longint          dx, dy, d2, t2;
        pdm_pkg::t_entry e;
        bit              hit;
        tsel = (d.source_id > SOURCE_SPLIT) ? 0 : 1;
        o.action = pdm_pkg::ACT_IGNORED;
        idx = 0;
        hit = 1'b0;
        case (d.kind)
            pdm_pkg::KIND_START: begin
                stored_count[0] = 0;
                stored_count[1] = 0;
                accepting = 1'b1;
                o.action = pdm_pkg::ACT_STARTED;
            end
            pdm_pkg::KIND_STOP: begin
                accepting = 1'b0;
                o.action = pdm_pkg::ACT_STOPPED;
            end
            pdm_pkg::KIND_DETECTION: begin
                if (accepting) begin
                    t2 = longint'(near_thr) * longint'(near_thr);
                    n = stored_count[tsel];
                    // first stored entry strictly inside the radius wins
                    for (int j = 0; j < n && !hit; j++) begin
                        e = stored_entry[tsel][j];
                        dx = longint'($signed(d.pos_x)) - longint'($signed(e.x));
                        dy = longint'($signed(d.pos_y)) - longint'($signed(e.y));
                        d2 = dx * dx + dy * dy;
                        if (d2 < t2) begin
                            hit = 1'b1;
                            idx = j;
                            if (avg_enable && e.cls == d.class_id) begin
                                e.x = 20'((longint'($signed(e.x)) + longint'($signed(d.pos_x))) >>> 1);
                                e.y = 20'((longint'($signed(e.y)) + longint'($signed(d.pos_y))) >>> 1);
                                o.action = pdm_pkg::ACT_AVERAGED;
                            end else if (d.confidence > e.conf) begin
                                e.cls = d.class_id;
                                o.action = pdm_pkg::ACT_REPLACED;
                            end else begin
                                o.action = pdm_pkg::ACT_UNCHANGED;
                            end
                            stored_entry[tsel][j] = e;
                        end
                    end
                    if (!hit) begin
                        if (n < TABLE_DEPTH) begin
                            e.cls = d.class_id;
                            e.conf = d.confidence;
                            e.x = d.pos_x;
                            e.y = d.pos_y;
                            stored_entry[tsel][n] = e;
                            stored_count[tsel] = n + 1;
                            idx = n;
                            o.action = pdm_pkg::ACT_APPENDED;
                        end else begin
                            o.action = pdm_pkg::ACT_DROPPED;
                        end
                    end
                end
            end
            default: o.action = pdm_pkg::ACT_IGNORED;
        endcase
        o.table_select = tsel[0];
        o.entry_index = 6'(idx);
        o.table_count = 7'(stored_count[tsel]);
        return o;
    endfunction

    function automatic int unsigned next_gap();
        int unsigned r;
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) calm_left = $urandom_range(20, 100);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 150);
    endfunction

    // Command driver: hold a transaction until accepted, then idle for a random gap.
    always @(negedge i_clk) begin
        t_detection d;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !cmd_taken) begin
            i_start <= 1'b1;
        end else if (gap_left != 0) begin
            i_start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_items.size() != 0) begin
            d = pending_items.pop_front();
            i_kind <= d.kind;
            i_source_id <= d.source_id;
            i_class_id <= d.class_id;
            i_confidence <= d.confidence;
            i_pos_x <= d.pos_x;
            i_pos_y <= d.pos_y;
            i_start <= 1'b1;
            gap_left <= next_gap();
        end else begin
            i_start <= 1'b0;
        end
    end

    // Result monitor: check strobed results, then predict the transaction accepted this edge.
    always @(posedge i_clk) begin
        t_outcome   want;
        t_detection seen;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= i_start && !o_busy;
            if (o_done === 1'b1) begin
                if (expected_results.size() == 0) begin
                    note_error("result strobe with no transaction outstanding");
                end else begin
                    want = expected_results.pop_front();
                    outstanding--;
                    if (o_action !== want.action || o_table_select !== want.table_select ||
                        o_entry_index !== want.entry_index ||
                        o_table_count !== want.table_count) begin
                        note_error($sformatf({"result mismatch (expected/actual): action %0d/%0d",
                            " select %0d/%0d index %0d/%0d count %0d/%0d"},
                            want.action, o_action, want.table_select, o_table_select,
                            want.entry_index, o_entry_index, want.table_count, o_table_count));
                    end
                end
            end
            if (i_start && !o_busy) begin
                seen.kind = i_kind;
                seen.source_id = i_source_id;
                seen.class_id = i_class_id;
                seen.confidence = i_confidence;
                seen.pos_x = i_pos_x;
                seen.pos_y = i_pos_y;
                expected_results = {expected_results, merge_detection(seen)};
            end
        end
    end

    task automatic queue_item(input t_detection d);
        pending_items = {pending_items, d};
        outstanding++;
    endtask

    task automatic queue_fields(input logic [1:0] kind, input int unsigned src,
                                input int unsigned cls, input int unsigned conf,
                                input int x, input int y);
        t_detection d;
        d.kind = kind;
        d.source_id = 10'(src);
        d.class_id = 8'(cls);
        d.confidence = 16'(conf);
        d.pos_x = 20'(x);
        d.pos_y = 20'(y);
        queue_item(d);
    endtask

    task automatic wait_idle();
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [pdm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == pdm_pkg::CFG_NEAR_THRESHOLD) near_thr = value;
        else avg_enable = value[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_detection random_detection();
        t_detection  d;
        int unsigned r;
        r = $urandom_range(0, 9);
        d.kind = pdm_pkg::KIND_DETECTION;
        if (r < 5) d.source_id = 10'($urandom);
        else if (r < 9) d.source_id = 10'($urandom_range(0, SOURCE_SPLIT));
        else d.source_id = 10'(SOURCE_SPLIT + $urandom_range(0, 1));
        d.class_id = 8'($urandom);
        d.confidence = 16'($urandom);
        d.pos_x = 20'($urandom);
        d.pos_y = 20'($urandom);
        return d;
    endfunction

    // One session: usually a start, detections clustered around a few objects, maybe a stop.
    task automatic random_session(input int unsigned radius);
        logic signed [19:0] cx [80];
        logic signed [19:0] cy [80];
        logic [7:0]         ccls [80];
        int unsigned        n_ctr, n_det, pick, r, spread;
        t_detection         d;
        n_ctr = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
        n_det = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 140) : $urandom_range(5, 40);
        for (int i = 0; i < n_ctr; i++) begin
            cx[i] = 20'($urandom);
            cy[i] = 20'($urandom);
            ccls[i] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        end
        if ($urandom_range(0, 99) < 85) begin
            d = random_detection();
            d.kind = pdm_pkg::KIND_START;
            queue_item(d);
            sent_count++;
        end
        repeat (n_det) begin
            d = random_detection();
            r = $urandom_range(0, 99);
            if (r < 85) begin
                pick = $urandom_range(0, n_ctr - 1);
                spread = (r < 60) ? radius * 2 / 3 : radius * 2;
                d.pos_x = 20'(int'(cx[pick]) + int'($urandom_range(0, 2 * spread)) - int'(spread));
                d.pos_y = 20'(int'(cy[pick]) + int'($urandom_range(0, 2 * spread)) - int'(spread));
                if ($urandom_range(0, 2) != 0) d.class_id = ccls[pick];
            end
            if ($urandom_range(0, 99) < 3) begin
                d.kind = KIND_UNUSED;
            end else begin
                sent_count++;
            end
            queue_item(d);
        end
        if ($urandom_range(0, 2) == 0) begin
            d = random_detection();
            d.kind = pdm_pkg::KIND_STOP;
            queue_item(d);
            sent_count++;
            repeat ($urandom_range(1, 4)) queue_item(random_detection());
        end
    endtask

    task automatic run_phase(input int unsigned radius, input bit avg);
        int goal;
        write_reg(pdm_pkg::CFG_NEAR_THRESHOLD, 16'(radius));
        write_reg(pdm_pkg::CFG_AVERAGE_ENABLE, {15'($urandom), avg});
        goal = sent_count + PHASE_ITEMS;
        while (sent_count < goal) random_session(radius);
        wait_idle();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: radius 200, no averaging.
        queue_fields(pdm_pkg::KIND_DETECTION, 100, 1, 1, 0, 0);
        queue_fields(KIND_UNUSED, 0, 2, 3, 4, 5);
        queue_fields(pdm_pkg::KIND_START, 0, 0, 0, 0, 0);
        queue_fields(pdm_pkg::KIND_DETECTION, 100, 5, 1000, 0, 0);
        queue_fields(pdm_pkg::KIND_DETECTION, SOURCE_SPLIT, 255, 65535, 524287, -524288);
        queue_fields(pdm_pkg::KIND_DETECTION, 1023, 7, 2000, 100, 100);
        queue_fields(pdm_pkg::KIND_DETECTION, 1023, 7, 0, 100, 100);
        // exactly on the radius: no match
        queue_fields(pdm_pkg::KIND_DETECTION, 100, 6, 10, 200, 0);
        // inside two entries: the earlier one must win
        queue_fields(pdm_pkg::KIND_DETECTION, 500, 8, 1000, 199, 0);
        queue_fields(pdm_pkg::KIND_DETECTION, 0, 0, 0, -524288, 524287);
        queue_fields(pdm_pkg::KIND_STOP, 100, 0, 0, 0, 0);
        queue_fields(pdm_pkg::KIND_DETECTION, 0, 9, 9, 0, 0);
        queue_fields(pdm_pkg::KIND_START, 1023, 0, 0, 0, 0);
        wait_idle();

        // Averaging: negative floor halves, class replacement keeps stored confidence.
        write_reg(pdm_pkg::CFG_AVERAGE_ENABLE, 16'd1);
        write_reg(pdm_pkg::CFG_NEAR_THRESHOLD, 16'd200);
        queue_fields(pdm_pkg::KIND_START, 500, 0, 0, 0, 0);
        queue_fields(pdm_pkg::KIND_DETECTION, 5, 9, 100, -3, -5);
        queue_fields(pdm_pkg::KIND_DETECTION, 5, 9, 50, 0, 0);
        queue_fields(pdm_pkg::KIND_DETECTION, 5, 10, 200, 1, 1);
        queue_fields(pdm_pkg::KIND_DETECTION, 5, 11, 100, 0, 0);
        queue_fields(pdm_pkg::KIND_DETECTION, 5, 10, 0, 0, 0);
        wait_idle();

        run_phase(0, 1'b0);
        run_phase(65535, 1'b1);
        run_phase(200, 1'b1);
        run_phase(1, 1'b0);
        run_phase($urandom_range(2, 65534), 1'($urandom));
        run_phase(200, 1'b0);
        run_phase(65535, 1'b0);
        run_phase(0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pdm_pkg.sv
hdl/proximity_detection_merger_unit.sv
dv/proximity_detection_merger_unit_tb.sv
